// ===== hdl/ufcs_pkg.sv =====
package ufcs_pkg;

   // Frame layout
   localparam int unsigned BODY_LEN    = 18;
   localparam logic [4:0]  POS_HUNT    = 5'd0;
   localparam logic [4:0]  POS_HEADER2 = 5'd1;
   localparam logic [4:0]  POS_CHECK   = 5'd20;

   // Result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_SUM = 2'd1;
   localparam logic [1:0] STATUS_STALE   = 2'd2;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [0:0]  CSR_HEADER_BYTE = 1'd0;
   localparam logic [0:0]  CSR_WRAP_WINDOW = 1'd1;

   localparam logic [7:0] HEADER_RESET = 8'hA5;
   localparam logic [7:0] WINDOW_RESET = 8'd100;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_AW    = 1;

   // One completed frame as handed from front to back
   typedef struct packed {
      logic        sum_ok;
      logic [7:0]  seq;
      logic [7:0]  id;
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
   } frame_type;

endpackage

// ===== hdl/uart_frame_checksum_seq_parser_unit.sv =====
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+------------------------------------------
// req       | in        | req_valid/req_ready  | req_rx_byte[7:0]
// rsp       | out       | rsp_valid/rsp_ready  | rsp_status, rsp_frame_seq, rsp_frame_id,
//           |           |                      | rsp_word0..rsp_word3
// csr       | in        | csr_write_en         | csr_index[0:0], csr_wdata[7:0]
//
// One received byte is taken every cycle while the two-entry frame queue has room.
// A result goes from the checksum byte into a queue entry and then into the output
// register. Reset (synchronous) clears position, sum, queue, output valid and last
// sequence, and loads header 0xA5 and window 100.
// A stalled rsp side fills the queue; only then does req_ready drop.
module uart_frame_checksum_seq_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_frame_seq,
   output logic [7:0]  rsp_frame_id,
   output logic [31:0] rsp_word0,
   output logic [31:0] rsp_word1,
   output logic [31:0] rsp_word2,
   output logic [31:0] rsp_word3,
   input  logic        csr_write_en,
   input  logic [ufcs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [7:0]          header_ff;
   logic [7:0]          window_ff;
   logic                push;
   logic                pop;
   logic                queue_full;
   logic                queue_not_empty;
   ufcs_pkg::frame_type push_frame;
   ufcs_pkg::frame_type head_frame;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= ufcs_pkg::HEADER_RESET;
         window_ff <= ufcs_pkg::WINDOW_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            ufcs_pkg::CSR_HEADER_BYTE: header_ff <= csr_wdata;
            ufcs_pkg::CSR_WRAP_WINDOW: window_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ufcs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_valid),
      .byte_data   (req_rx_byte),
      .queue_full  (queue_full),
      .header_byte (header_ff),
      .byte_ready  (req_ready),
      .push        (push),
      .push_frame  (push_frame)
   );

   ufcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head_frame (head_frame)
   );

   ufcs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (queue_not_empty),
      .head_frame    (head_frame),
      .wrap_window   (window_ff),
      .rsp_ready     (rsp_ready),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_frame_seq (rsp_frame_seq),
      .rsp_frame_id  (rsp_frame_id),
      .rsp_word0     (rsp_word0),
      .rsp_word1     (rsp_word1),
      .rsp_word2     (rsp_word2),
      .rsp_word3     (rsp_word3)
   );

endmodule

// ===== hdl/ufcs_front.sv =====
module ufcs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  logic [7:0]           byte_data,
   input  logic                 queue_full,
   input  logic [7:0]           header_byte,
   output logic                 byte_ready,
   output logic                 push,
   output ufcs_pkg::frame_type  push_frame
);

   logic [4:0] pos_ff;
   logic [4:0] pos_in;
   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic [7:0] body_ff [ufcs_pkg::BODY_LEN];
   logic       take;
   logic       body_byte;
   logic       check_byte;

   assign byte_ready = !queue_full;
   assign take       = byte_valid && byte_ready;
   assign body_byte  = (pos_ff > ufcs_pkg::POS_HEADER2) && (pos_ff < ufcs_pkg::POS_CHECK);
   assign check_byte = (pos_ff == ufcs_pkg::POS_CHECK);
   assign push       = take && check_byte;

   // Classify the byte by its place in the frame
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (take) begin
         if (pos_ff == ufcs_pkg::POS_HEADER2) begin
            pos_in = (byte_data == header_byte) ? 5'd2 : ufcs_pkg::POS_HUNT;
            sum_in = 8'd0;
         end else if (body_byte) begin
            pos_in = pos_ff + 5'd1;
            sum_in = sum_ff + byte_data;
         end else if (check_byte) begin
            pos_in = ufcs_pkg::POS_HUNT;
            sum_in = 8'd0;
         end else begin
            pos_in = (byte_data == header_byte) ? ufcs_pkg::POS_HEADER2 : ufcs_pkg::POS_HUNT;
            sum_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= ufcs_pkg::POS_HUNT;
         sum_ff <= 8'd0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // Shift body bytes in; the oldest ends at entry zero
   always_ff @(posedge clock) begin
      if (take && body_byte) begin
         for (int i = 0; i < ufcs_pkg::BODY_LEN - 1; i++) begin
            body_ff[i] <= body_ff[i+1];
         end
         body_ff[ufcs_pkg::BODY_LEN-1] <= byte_data;
      end
   end

   // Pack the finished frame for the back end
   always_comb begin
      push_frame.sum_ok = (byte_data == sum_ff);
      push_frame.seq    = body_ff[0];
      push_frame.id     = body_ff[1];
      push_frame.word0  = {body_ff[5],  body_ff[4],  body_ff[3],  body_ff[2]};
      push_frame.word1  = {body_ff[9],  body_ff[8],  body_ff[7],  body_ff[6]};
      push_frame.word2  = {body_ff[13], body_ff[12], body_ff[11], body_ff[10]};
      push_frame.word3  = {body_ff[17], body_ff[16], body_ff[15], body_ff[14]};
   end

endmodule

// ===== hdl/ufcs_queue.sv =====
module ufcs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ufcs_pkg::frame_type  push_frame,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output ufcs_pkg::frame_type  head_frame
);

   ufcs_pkg::frame_type entry_ff [ufcs_pkg::QUEUE_DEPTH];
   logic [ufcs_pkg::QUEUE_AW-1:0] wr_ptr_ff;
   logic [ufcs_pkg::QUEUE_AW-1:0] rd_ptr_ff;
   logic [ufcs_pkg::QUEUE_AW:0]   count_ff;
   logic [ufcs_pkg::QUEUE_AW:0]   count_in;

   localparam logic [ufcs_pkg::QUEUE_AW:0] FULL_COUNT =
      (ufcs_pkg::QUEUE_AW+1)'(ufcs_pkg::QUEUE_DEPTH);
   localparam logic [ufcs_pkg::QUEUE_AW-1:0] LAST_SLOT =
      ufcs_pkg::QUEUE_AW'(ufcs_pkg::QUEUE_DEPTH - 1);

   assign full       = (count_ff == FULL_COUNT);
   assign not_empty  = (count_ff != '0);
   assign head_frame = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   // Hold frame data
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// ===== hdl/ufcs_back.sv =====
module ufcs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  ufcs_pkg::frame_type  head_frame,
   input  logic [7:0]           wrap_window,
   input  logic                 rsp_ready,
   output logic                 pop,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [7:0]           rsp_frame_seq,
   output logic [7:0]           rsp_frame_id,
   output logic [31:0]          rsp_word0,
   output logic [31:0]          rsp_word1,
   output logic [31:0]          rsp_word2,
   output logic [31:0]          rsp_word3
);

   logic        valid_ff;
   logic [7:0]  last_seq_ff;
   logic [1:0]  status_ff;
   logic [1:0]  status_in;
   logic [7:0]  seq_ff;
   logic [7:0]  id_ff;
   logic [31:0] word0_ff;
   logic [31:0] word1_ff;
   logic [31:0] word2_ff;
   logic [31:0] word3_ff;
   logic        newer;
   logic        wrapped;
   logic        fresh;
   logic [7:0]  back_dist;

   assign pop = head_valid && (!valid_ff || rsp_ready);

   // Judge sequence freshness against the last accepted frame
   assign back_dist = last_seq_ff - head_frame.seq;
   assign newer     = head_frame.seq > last_seq_ff;
   assign wrapped   = (last_seq_ff > head_frame.seq) && (back_dist > wrap_window);
   assign fresh     = head_frame.sum_ok && (newer || wrapped);

   always_comb begin
      if (!head_frame.sum_ok) begin
         status_in = ufcs_pkg::STATUS_BAD_SUM;
      end else if (newer || wrapped) begin
         status_in = ufcs_pkg::STATUS_OK;
      end else begin
         status_in = ufcs_pkg::STATUS_STALE;
      end
   end

   // Control: output valid and last sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         last_seq_ff <= 8'd0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
         if (pop && fresh) begin
            last_seq_ff <= head_frame.seq;
         end
      end
   end

   // Load the result; rejected frames carry zero fields
   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         seq_ff    <= fresh ? head_frame.seq   : 8'd0;
         id_ff     <= fresh ? head_frame.id    : 8'd0;
         word0_ff  <= fresh ? head_frame.word0 : 32'd0;
         word1_ff  <= fresh ? head_frame.word1 : 32'd0;
         word2_ff  <= fresh ? head_frame.word2 : 32'd0;
         word3_ff  <= fresh ? head_frame.word3 : 32'd0;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_frame_seq = seq_ff;
   assign rsp_frame_id  = id_ff;
   assign rsp_word0     = word0_ff;
   assign rsp_word1     = word1_ff;
   assign rsp_word2     = word2_ff;
   assign rsp_word3     = word3_ff;

endmodule
